@@ rtl/ppst_pkg.sv @@
// ---------------------------------------------------------------------------
// ppst_pkg
// Shared widths, register indexes, reset values and sideband types.
// ---------------------------------------------------------------------------
package ppst_pkg;

  localparam int FRAC_BITS = 16;

  localparam int CNT_W   = 16;
  localparam int CRD_W   = 24;
  localparam int REG_W   = 23;
  localparam int ANG_W   = 24;
  localparam int MAG_W   = 24;
  localparam int SQR_W   = 2 * MAG_W;        // one squared magnitude
  localparam int RAD_W   = SQR_W + 1;        // sum of two squares
  localparam int ROOT_W  = 25;
  localparam int SQ_REM_W = ROOT_W + 3;
  localparam int NUM_W   = REG_W + MAG_W + 1;
  localparam int DEN_W   = REG_W + ROOT_W;
  localparam int QW      = ANG_W;            // quotient bits before clamp
  localparam int NW      = NUM_W + FRAC_BITS;
  localparam int LIM2_W  = 2 * REG_W;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR_LIMIT      = 3'd0,
    CFG_MID_LIMIT       = 3'd1,
    CFG_FAR_LIMIT       = 3'd2,
    CFG_CRUISE_SPEED    = 3'd3,
    CFG_LOOKAHEAD_SHORT = 3'd4,
    CFG_LOOKAHEAD_MID   = 3'd5,
    CFG_LOOKAHEAD_LONG  = 3'd6
  } cfg_idx_t;

  localparam logic [REG_W-1:0] RST_NEAR_LIMIT      = 23'd196608;
  localparam logic [REG_W-1:0] RST_MID_LIMIT       = 23'd327680;
  localparam logic [REG_W-1:0] RST_FAR_LIMIT       = 23'd524288;
  localparam logic [REG_W-1:0] RST_CRUISE_SPEED    = 23'd13107;
  localparam logic [REG_W-1:0] RST_LOOKAHEAD_SHORT = 23'd65667;
  localparam logic [REG_W-1:0] RST_LOOKAHEAD_MID   = 23'd99615;
  localparam logic [REG_W-1:0] RST_LOOKAHEAD_LONG  = 23'd137626;

  localparam logic [ANG_W-1:0] LIM_POS = 24'h7FFFFF;
  localparam logic [ANG_W-1:0] LIM_NEG = 24'h800000;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [REG_W-1:0] look;
    logic [REG_W-1:0] lin;
    logic             zero;
    logic             neg;
  } sq_side_t;

  typedef struct packed {
    logic [REG_W-1:0] lin;
    logic             zero;
    logic             neg;
    logic             sat;
  } dv_side_t;

endpackage

@@ rtl/pure_pursuit_steering.sv @@
// ---------------------------------------------------------------------------
// pure_pursuit_steering
// Pure pursuit path tracker: path summary in, velocity command out.
// ---------------------------------------------------------------------------
// Takes one item per clock while the pipeline advances and gives one result
// per item. The pipeline is made of the bit-serial square root (25 stages)
// and the restoring divider (24 stages), plus three front stages, a product
// stage, a divider setup stage and the output register. The whole pipeline
// advances whenever the output register is empty or being taken, so
// s_tready follows m_tready. Configuration writes are taken every cycle;
// the squared band limits follow in the cycle after a write.
module pure_pursuit_steering import ppst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // {goal_y, goal_x, next_y, next_x, start_y, start_x, point_count}, lsb first
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [159:0]         s_tdata,
  // {pad, yaw_rate, fwd_speed}, lsb first
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [47:0]          m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  // ---- configuration registers
  logic [REG_W-1:0]  near_limit, mid_limit, far_limit, cruise_speed;
  logic [REG_W-1:0]  lookahead_short, lookahead_mid, lookahead_long;
  logic [LIM2_W-1:0] near_sq, mid_sq, far_sq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_limit      <= RST_NEAR_LIMIT;
      mid_limit       <= RST_MID_LIMIT;
      far_limit       <= RST_FAR_LIMIT;
      cruise_speed    <= RST_CRUISE_SPEED;
      lookahead_short <= RST_LOOKAHEAD_SHORT;
      lookahead_mid   <= RST_LOOKAHEAD_MID;
      lookahead_long  <= RST_LOOKAHEAD_LONG;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NEAR_LIMIT:      near_limit      <= cfg_data;
        CFG_MID_LIMIT:       mid_limit       <= cfg_data;
        CFG_FAR_LIMIT:       far_limit       <= cfg_data;
        CFG_CRUISE_SPEED:    cruise_speed    <= cfg_data;
        CFG_LOOKAHEAD_SHORT: lookahead_short <= cfg_data;
        CFG_LOOKAHEAD_MID:   lookahead_mid   <= cfg_data;
        CFG_LOOKAHEAD_LONG:  lookahead_long  <= cfg_data;
        default: ;
      endcase
    end
  end

  // band limits are compared squared
  always_ff @(posedge clk) begin
    near_sq <= near_limit * near_limit;
    mid_sq  <= mid_limit * mid_limit;
    far_sq  <= far_limit * far_limit;
  end

  // ---- global advance: output register empty or drained
  logic en;
  logic o_valid;

  assign en       = !o_valid || m_tready;
  assign s_tready = en;

  // ---- stage 1: differences and magnitudes
  logic [CNT_W-1:0] point_count;
  logic signed [CRD_W-1:0] start_x, start_y, next_x, next_y, goal_x, goal_y;

  assign point_count = s_tdata[15:0];
  assign start_x     = s_tdata[39:16];
  assign start_y     = s_tdata[63:40];
  assign next_x      = s_tdata[87:64];
  assign next_y      = s_tdata[111:88];
  assign goal_x      = s_tdata[135:112];
  assign goal_y      = s_tdata[159:136];

  logic signed [CRD_W:0] gdx_s, gdy_s, lat_s, fwd_s;

  assign gdx_s = $signed({goal_x[CRD_W-1], goal_x}) - $signed({start_x[CRD_W-1], start_x});
  assign gdy_s = $signed({goal_y[CRD_W-1], goal_y}) - $signed({start_y[CRD_W-1], start_y});
  assign lat_s = $signed({next_y[CRD_W-1], next_y}) - $signed({start_y[CRD_W-1], start_y});
  assign fwd_s = $signed({next_x[CRD_W-1], next_x}) - $signed({start_x[CRD_W-1], start_x});

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [CRD_W:0] d);
    logic [CRD_W:0] m;
    m = d[CRD_W] ? (CRD_W+1)'(-d) : d;
    return m[MAG_W-1:0];
  endfunction

  logic             a_valid, a_short, a_neg, a_latz;
  logic [MAG_W-1:0] a_gdx, a_gdy, a_lmag, a_fmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= s_tvalid;
    end
    if (en) begin
      a_short <= point_count <= CNT_W'(2);
      a_neg   <= lat_s[CRD_W];
      a_latz  <= lat_s == '0;
      a_gdx   <= mag_of(gdx_s);
      a_gdy   <= mag_of(gdy_s);
      a_lmag  <= mag_of(lat_s);
      a_fmag  <= mag_of(fwd_s);
    end
  end

  // ---- stage 2: squares and speed * |lateral|
  logic               b_valid, b_short, b_neg, b_latz;
  logic [SQR_W-1:0]   b_gx2, b_gy2, b_l2, b_f2;
  logic [NUM_W-2:0]   b_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      b_short <= a_short;
      b_neg   <= a_neg;
      b_latz  <= a_latz;
      b_gx2   <= a_gdx * a_gdx;
      b_gy2   <= a_gdy * a_gdy;
      b_l2    <= a_lmag * a_lmag;
      b_f2    <= a_fmag * a_fmag;
      b_num   <= cruise_speed * a_lmag;
    end
  end

  // ---- stage 3: sums of squares
  logic             c_valid, c_short, c_neg, c_latz;
  logic [RAD_W-1:0] c_d2, c_s;
  logic [NUM_W-2:0] c_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
    if (en) begin
      c_short <= b_short;
      c_neg   <= b_neg;
      c_latz  <= b_latz;
      c_d2    <= RAD_W'(b_gx2) + RAD_W'(b_gy2);
      c_s     <= RAD_W'(b_l2) + RAD_W'(b_f2);
      c_num   <= b_num;
    end
  end

  // ---- band choice, feeding the square root
  logic             stop;
  logic [REG_W-1:0] look;
  sq_side_t         sq_in;

  always_comb begin
    stop = c_d2 <= RAD_W'(near_sq);
    if (c_d2 <= RAD_W'(mid_sq)) begin
      look = lookahead_short;
    end else if (c_d2 <= RAD_W'(far_sq)) begin
      look = lookahead_mid;
    end else begin
      look = lookahead_long;
    end
    sq_in.num  = {c_num, 1'b0};
    sq_in.look = look;
    sq_in.lin  = (c_short || stop) ? '0 : cruise_speed;
    sq_in.zero = c_short || stop || c_latz || (look == '0);
    sq_in.neg  = c_neg;
  end

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  sq_side_t          sq_out;

  ppst_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_valid),
    .in_rad    (c_s),
    .in_side   (sq_in),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_out)
  );

  // ---- divisor = lookahead * distance to the next point
  logic             e_valid;
  logic [DEN_W-1:0] e_den;
  sq_side_t         e_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= sq_valid;
    end
    if (en) begin
      e_den  <= sq_out.look * sq_root;
      e_side <= sq_out;
    end
  end

  // ---- divider setup: quotient of 2^24 or more saturates, that is
  // when the dividend bits above the quotient width reach the divisor
  logic [NW-1:0]    dividend;
  logic             f_valid;
  logic [DEN_W-1:0] f_rem, f_den;
  logic [QW-1:0]    f_low;
  dv_side_t         f_side;

  assign dividend = NW'(e_side.num) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= e_valid;
    end
    if (en) begin
      f_rem       <= DEN_W'(dividend[NW-1:QW]);
      f_low       <= dividend[QW-1:0];
      f_den       <= e_den;
      f_side.lin  <= e_side.lin;
      f_side.zero <= e_side.zero;
      f_side.neg  <= e_side.neg;
      f_side.sat  <= DEN_W'(dividend[NW-1:QW]) >= e_den;
    end
  end

  logic          dv_valid;
  logic [QW-1:0] dv_quo;
  dv_side_t      dv_out;

  ppst_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_rem    (f_rem),
    .in_low    (f_low),
    .in_den    (f_den),
    .in_side   (f_side),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_out)
  );

  // ---- clamp, sign and output register
  logic [ANG_W-1:0] lim, qmag, ang;
  logic [REG_W-1:0] o_lin;
  logic [ANG_W-1:0] o_ang;

  always_comb begin
    lim  = dv_out.neg ? LIM_NEG : LIM_POS;
    qmag = (dv_out.sat || dv_quo > lim) ? lim : dv_quo;
    if (dv_out.zero) begin
      ang = '0;
    end else if (dv_out.neg) begin
      ang = ANG_W'(-qmag);
    end else begin
      ang = qmag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= dv_valid;
    end
    if (en) begin
      o_lin <= dv_out.lin;
      o_ang <= ang;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {1'b0, o_ang, o_lin};

endmodule

@@ rtl/ppst_sqrt.sv @@
// ---------------------------------------------------------------------------
// ppst_sqrt
// Pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module ppst_sqrt import ppst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  in_rad,
  input  sq_side_t          in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output sq_side_t          out_side
);

  logic                    v    [ROOT_W+1];
  logic [SQ_REM_W-1:0]     rem  [ROOT_W+1];
  logic [ROOT_W-1:0]       root [ROOT_W+1];
  logic [2*ROOT_W-1:0]     rad  [ROOT_W+1];
  sq_side_t                side [ROOT_W+1];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic                cur_v;
    logic [SQ_REM_W-1:0] cur_rem;
    logic [ROOT_W-1:0]   cur_root;
    logic [2*ROOT_W-1:0] cur_rad;
    sq_side_t            cur_side;
    logic [SQ_REM_W-1:0] t_rem;
    logic [SQ_REM_W-1:0] trial;
    logic [SQ_REM_W-1:0] n_rem;
    logic [ROOT_W-1:0]   n_root;

    if (k == 0) begin : g_first
      assign cur_v    = in_valid;
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_rad  = (2*ROOT_W)'(in_rad);
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_v    = v[k];
      assign cur_rem  = rem[k];
      assign cur_root = root[k];
      assign cur_rad  = rad[k];
      assign cur_side = side[k];
    end

    assign t_rem = {cur_rem[SQ_REM_W-3:0], cur_rad[2*ROOT_W-1 -: 2]};
    assign trial = SQ_REM_W'({cur_root, 2'b01});

    always_comb begin
      if (t_rem >= trial) begin
        n_rem  = t_rem - trial;
        n_root = {cur_root[ROOT_W-2:0], 1'b1};
      end else begin
        n_rem  = t_rem;
        n_root = {cur_root[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= cur_v;
      end
      if (en) begin
        rem[k+1]  <= n_rem;
        root[k+1] <= n_root;
        rad[k+1]  <= {cur_rad[2*ROOT_W-3:0], 2'b00};
        side[k+1] <= cur_side;
      end
    end
  end

  // stage zero reads the inputs directly; these unused entries are tied to zero
  assign v[0]    = 1'b0;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = '0;
  assign side[0] = '0;

  assign out_valid = v[ROOT_W];
  assign out_root  = root[ROOT_W];
  assign out_side  = side[ROOT_W];

endmodule

@@ rtl/ppst_div.sv @@
// ---------------------------------------------------------------------------
// ppst_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module ppst_div import ppst_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DEN_W-1:0] in_rem,   // upper dividend bits, expected below divisor; not enforced here
  input  logic [QW-1:0]    in_low,   // lower dividend bits, msb first
  input  logic [DEN_W-1:0] in_den,
  input  dv_side_t         in_side,
  output logic             out_valid,
  output logic [QW-1:0]    out_quo,
  output dv_side_t         out_side
);

  logic             v    [QW+1];
  logic [DEN_W-1:0] rem  [QW+1];
  logic [QW-1:0]    low  [QW+1];
  logic [QW-1:0]    quo  [QW+1];
  logic [DEN_W-1:0] den  [QW+1];
  dv_side_t         side [QW+1];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic             cur_v;
    logic [DEN_W-1:0] cur_rem;
    logic [QW-1:0]    cur_low;
    logic [QW-1:0]    cur_quo;
    logic [DEN_W-1:0] cur_den;
    dv_side_t         cur_side;
    logic [DEN_W:0]   t_rem;
    logic             take;

    if (k == 0) begin : g_first
      assign cur_v    = in_valid;
      assign cur_rem  = in_rem;
      assign cur_low  = in_low;
      assign cur_quo  = '0;
      assign cur_den  = in_den;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_v    = v[k];
      assign cur_rem  = rem[k];
      assign cur_low  = low[k];
      assign cur_quo  = quo[k];
      assign cur_den  = den[k];
      assign cur_side = side[k];
    end

    assign t_rem = {cur_rem, cur_low[QW-1]};
    assign take  = t_rem >= {1'b0, cur_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= cur_v;
      end
      if (en) begin
        rem[k+1]  <= take ? DEN_W'(t_rem - {1'b0, cur_den}) : DEN_W'(t_rem);
        low[k+1]  <= {cur_low[QW-2:0], 1'b0};
        quo[k+1]  <= {cur_quo[QW-2:0], take};
        den[k+1]  <= cur_den;
        side[k+1] <= cur_side;
      end
    end
  end

  assign v[0]    = 1'b0;
  assign rem[0]  = '0;
  assign low[0]  = '0;
  assign quo[0]  = '0;
  assign den[0]  = '0;
  assign side[0] = '0;

  assign out_valid = v[QW];
  assign out_quo   = quo[QW];
  assign out_side  = side[QW];

endmodule

@@ dv/ppst_checker.sv @@
// ---------------------------------------------------------------------------
// ppst_checker
// Predicts and checks pure_pursuit_steering velocity commands.
// ---------------------------------------------------------------------------
// Mirrors the register file from the write channel, computes the expected
// command for every accepted path summary and checks each output item
// against the oldest expected command, field by field.
module ppst_checker import ppst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [159:0]         s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [47:0]          m_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [REG_W-1:0] lin;
    logic [ANG_W-1:0] ang;
  } cmd_t;

  logic [REG_W-1:0] near_r, mid_r, far_r, speed_r, la_short, la_mid, la_long;
  cmd_t cmd_q[$];

  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned res;
    longint unsigned trial;
    res = 0;
    for (int b = 25; b >= 0; b--) begin
      trial = res | (64'd1 << b);
      if (trial * trial <= s) res = trial;
    end
    return res;
  endfunction

  function automatic cmd_t steer_cmd(logic [159:0] d);
    cmd_t c;
    longint sx, sy, nx, ny, gx, gy, lat, fwd;
    longint unsigned gdx, gdy, d2, look, lmag, fmag, r, num, den, lim;
    logic [127:0] q;
    c = '0;
    if (d[15:0] <= 16'd2) return c;
    sx = $signed(d[39:16]);
    sy = $signed(d[63:40]);
    nx = $signed(d[87:64]);
    ny = $signed(d[111:88]);
    gx = $signed(d[135:112]);
    gy = $signed(d[159:136]);
    gdx = (gx - sx < 0) ? -(gx - sx) : gx - sx;
    gdy = (gy - sy < 0) ? -(gy - sy) : gy - sy;
    d2 = gdx * gdx + gdy * gdy;
    // band choice on squared distances, near first
    if (d2 <= 64'(near_r) * 64'(near_r)) return c;
    if (d2 <= 64'(mid_r) * 64'(mid_r)) look = la_short;
    else if (d2 <= 64'(far_r) * 64'(far_r)) look = la_mid;
    else look = la_long;
    c.lin = speed_r;
    lat = ny - sy;
    fwd = nx - sx;
    if (lat == 0 || look == 0) return c;
    lmag = (lat < 0) ? -lat : lat;
    fmag = (fwd < 0) ? -fwd : fwd;
    r = root_floor(lmag * lmag + fmag * fmag);
    if (r == 0) return c;
    num = 2 * 64'(speed_r) * lmag;
    den = look * r;
    lim = (lat > 0) ? 64'h7FFFFF : 64'h800000;
    q = {64'd0, num} << FRAC_BITS;
    q = q / {64'd0, den};
    if (q > {64'd0, lim}) q = {64'd0, lim};
    c.ang = (lat > 0) ? q[ANG_W-1:0] : -q[ANG_W-1:0];
    return c;
  endfunction

  always @(posedge clk) begin
    cmd_t want;
    cmd_t got;
    int   n_err;
    n_err = 0;
    if (rst) begin
      near_r   <= RST_NEAR_LIMIT;
      mid_r    <= RST_MID_LIMIT;
      far_r    <= RST_FAR_LIMIT;
      speed_r  <= RST_CRUISE_SPEED;
      la_short <= RST_LOOKAHEAD_SHORT;
      la_mid   <= RST_LOOKAHEAD_MID;
      la_long  <= RST_LOOKAHEAD_LONG;
      cmd_q.delete();
      errors   <= 0;
      pending  <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_NEAR_LIMIT:      near_r   <= cfg_data;
          CFG_MID_LIMIT:       mid_r    <= cfg_data;
          CFG_FAR_LIMIT:       far_r    <= cfg_data;
          CFG_CRUISE_SPEED:    speed_r  <= cfg_data;
          CFG_LOOKAHEAD_SHORT: la_short <= cfg_data;
          CFG_LOOKAHEAD_MID:   la_mid   <= cfg_data;
          CFG_LOOKAHEAD_LONG:  la_long  <= cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) cmd_q.push_back(steer_cmd(s_tdata));
      if (m_tvalid && m_tready) begin
        got.lin = m_tdata[22:0];
        got.ang = m_tdata[46:23];
        if (cmd_q.size() == 0) begin
          $error("unexpected output item lin=%0d ang=%0d", got.lin, $signed(got.ang));
          n_err++;
        end else begin
          want = cmd_q.pop_front();
          if (want.lin !== got.lin) begin
            $error("fwd_speed expected %0d actual %0d", want.lin, got.lin);
            n_err++;
          end
          if (want.ang !== got.ang) begin
            $error("yaw_rate expected %0d actual %0d",
                   $signed(want.ang), $signed(got.ang));
            n_err++;
          end
        end
      end
      errors  <= errors + n_err;
      pending <= cmd_q.size();
    end
  end
endmodule

@@ dv/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Stimulus and verdict for pure_pursuit_steering.
// ---------------------------------------------------------------------------
// Drives directed and random path summaries through several register
// settings and idle patterns; ppst_checker predicts and compares.
module testbench;
  import ppst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY  = 55;
  localparam int WD_LIMIT = 5000;   // cycles with no handshake at all
  localparam int Q1       = 1 << FRAC_BITS;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [159:0]         s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [47:0]          m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;
  int                   errors;
  int                   pending;

  // idle percentages for the current phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  always #2 clk = ~clk;

  pure_pursuit_steering u_top (.*);

  ppst_checker u_checker (.*);

  // receiver back-pressure
  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // watchdog: nothing moving on any channel for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic logic [159:0] pack_path(int cnt, int sx, int sy, int nx, int ny,
                                             int gx, int gy);
    return {gy[23:0], gx[23:0], ny[23:0], nx[23:0], sy[23:0], sx[23:0], cnt[15:0]};
  endfunction

  // mostly metre-scale coordinates, sometimes full 24-bit range
  function automatic int rand_coord();
    if ($urandom_range(99) < 30) return int'($urandom);
    return int'($urandom_range(2 * 12 * Q1)) - 12 * Q1;
  endfunction

  function automatic int rand_offset();
    return int'($urandom_range(2 * 10 * Q1)) - 10 * Q1;
  endfunction

  // one path summary; valid stays high across back-to-back items
  task automatic send_path(logic [159:0] item);
    logic rdy;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= item;
    do begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end while (!rdy);
  endtask

  // hold off until every command is back, then let the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic load_regs(logic [REG_W-1:0] v[7]);
    logic rdy;
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= v[i];
      do begin
        @(negedge clk);
        rdy = cfg_ready;
        @(posedge clk);
      end while (!rdy);
    end
    cfg_valid <= 1'b0;
    repeat (3) @(posedge clk);
  endtask

  task automatic random_paths(int n);
    int cnt, sx, sy;
    for (int i = 0; i < n; i++) begin
      sx = rand_coord();
      sy = rand_coord();
      case ($urandom_range(9))
        0:       cnt = $urandom_range(2);
        1:       cnt = $urandom_range(65535);
        default: cnt = $urandom_range(3, 200);
      endcase
      if ($urandom_range(9) == 0)
        send_path(pack_path(cnt, sx, sy, rand_coord(), rand_coord(),
                            rand_coord(), rand_coord()));
      else
        send_path(pack_path(cnt, sx, sy, sx + rand_offset() / 8,
                            ($urandom_range(15) == 0) ? sy : sy + rand_offset() / 8,
                            sx + rand_offset(), sy + rand_offset()));
    end
  endtask

  initial begin
    logic [REG_W-1:0] regs[7];
    int mode;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed: short paths, stop band, bands, straight ahead, extremes
    send_path(pack_path(0, 0, 0, Q1, Q1, 10 * Q1, 0));
    send_path(pack_path(1, 0, 0, Q1, Q1, 10 * Q1, 0));
    send_path(pack_path(2, 0, 0, Q1, Q1, 10 * Q1, 0));
    send_path(pack_path(3, 0, 0, Q1, Q1, 10 * Q1, 0));
    send_path(pack_path(65535, 0, 0, Q1, -Q1, 10 * Q1, 0));
    send_path(pack_path(3, Q1, Q1, 2 * Q1, 2 * Q1, Q1, Q1));          // goal on vehicle
    send_path(pack_path(3, 0, 0, Q1, Q1, 3 * Q1, 0));                 // near edge
    send_path(pack_path(3, 0, 0, Q1, Q1, 4 * Q1, 0));                 // short band
    send_path(pack_path(3, 0, 0, Q1, -Q1, 5 * Q1, 0));
    send_path(pack_path(3, 0, 0, Q1, Q1, 7 * Q1, 0));                 // middle band
    send_path(pack_path(3, 0, 0, Q1, -Q1, 8 * Q1, 0));
    send_path(pack_path(3, 0, 0, Q1, Q1, 0, 9 * Q1));                 // long band
    send_path(pack_path(3, 0, 0, 5 * Q1, 0, 10 * Q1, 0));             // no lateral offset
    send_path(pack_path(3, 0, 0, 0, 0, 10 * Q1, 0));                  // next on vehicle
    send_path(pack_path(3, 0, 0, 0, 1, 10 * Q1, 0));                  // tiny offset
    send_path(pack_path(3, 0, 0, 0, -1, 10 * Q1, 0));
    send_path(pack_path(3, -8388608, -8388608, 8388607, 8388607, 8388607, 8388607));
    send_path(pack_path(3, 8388607, 8388607, -8388608, -8388608, -8388608, -8388608));
    send_path(pack_path(3, -8388608, 8388607, 8388607, -8388608, 0, 0));
    send_path(pack_path(65535, 8388607, -8388608, -8388608, 8388607, -1, -1));
    drain();

    // settings: reset, random, all max, all zero, sane random, reset again
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: foreach (regs[i]) regs[i] = REG_W'($urandom);
        2: foreach (regs[i]) regs[i] = '1;
        3: foreach (regs[i]) regs[i] = '0;
        4: begin
          regs[0] = REG_W'($urandom_range(4 * Q1));
          regs[1] = REG_W'(regs[0] + $urandom_range(4 * Q1));
          regs[2] = REG_W'(regs[1] + $urandom_range(4 * Q1));
          regs[3] = REG_W'($urandom_range(1 << 22));
          for (int i = 4; i < 7; i++) regs[i] = REG_W'($urandom_range(1, 4 * Q1));
        end
        default: regs = '{RST_NEAR_LIMIT, RST_MID_LIMIT, RST_FAR_LIMIT,
                          RST_CRUISE_SPEED, RST_LOOKAHEAD_SHORT,
                          RST_LOOKAHEAD_MID, RST_LOOKAHEAD_LONG};
      endcase
      load_regs(regs);
      // two idle patterns per setting; every other setting has a stretch with none
      for (int k = 0; k < 2; k++) begin
        mode = (2 * ph + k) % 4;
        send_idle_pct  = (mode == 1) ? 80 : (mode == 3) ? 21 : 0;
        recv_stall_pct = (mode == 2) ? 80 : (mode == 3) ? 21 : 0;
        random_paths(100);
        if (k == 0) drain();   // sender holds off until all commands are back
      end
      drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain();
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
